// ===== hw/rtl/rtcpm_pkg.sv =====
`timescale 1ns / 1ps

package rtcpm_pkg;

   localparam int DIRECT_SIZE = 1024;
   localparam int RANGE_WORDS = 1024;
   localparam int DIR_AW      = $clog2(DIRECT_SIZE);
   localparam int RNG_AW      = $clog2(RANGE_WORDS);
   localparam int WORD_W      = 32;
   localparam int LPI_W       = 10;
   localparam int CSR_AW      = 3;

   localparam logic [WORD_W-1:0] MAX_CODE    = 32'h0010_FFFF;
   localparam logic [WORD_W-1:0] ACTION_BASE = 32'h0020_0000;
   localparam logic [WORD_W-1:0] ACT_CLEAR   = ACTION_BASE;
   localparam logic [WORD_W-1:0] ACT_SET     = ACTION_BASE + 32'd1;
   localparam logic [WORD_W-1:0] ACT_DEC_SET = ACTION_BASE + 32'd2;

   localparam logic [1:0] MODE_DIR_WR = 2'd0;
   localparam logic [1:0] MODE_RNG_WR = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_LAST_PAIR = 3'd0;

   typedef struct packed {
      logic [1:0]               mode;
      logic [9:0]               index;
      logic signed [WORD_W-1:0] value;
      logic signed [WORD_W-1:0] code;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] mapped_code;
      logic                     bad_action;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [DIR_AW-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [DIR_AW-1:0] raddr;
   } dir_ram_req_type;

   typedef struct packed {
      logic              we;
      logic [RNG_AW-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [RNG_AW-1:0] raddr;
   } rng_ram_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIR,
      ST_SEARCH,
      ST_CMP,
      ST_START,
      ST_ACT
   } state_type;

endpackage

// ===== hw/rtl/range_table_code_point_mapper_top.sv =====
`timescale 1ns / 1ps

// Code point mapper over a loaded direct table and a loaded range table.
// Items: raise start with req_data while busy is low; the item is taken at that edge.
// Mode 0 writes a direct table word, mode 1 writes a range table word; both are taken
// at once and busy stays low, so writes may follow every cycle with no result.
// Mode 2 queries a code; its result appears on rsp_data with rsp_valid for one cycle.
// Query paths: a code above 0x10FFFF (negative included) is answered without leaving
// idle; a code below the direct table size takes one direct table read; otherwise a
// binary search runs over the range table pairs, at most 9 steps with 512 pairs and one
// range table read per step, and the pair start and its action are then read and decoded.
// busy drops in the result cycle, so the next item may be taken then.
// The receiver cannot hold results off; rsp_valid is a single cycle strobe.
// Register last_pair_index at address 0 of the APB port (write when idle).
// Reset clears the control state and last_pair_index; table contents are undefined
// until written.
module range_table_code_point_mapper_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  rtcpm_pkg::req_type           req_data,
   output logic                         rsp_valid,
   output rtcpm_pkg::rsp_type           rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rtcpm_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import rtcpm_pkg::*;

   logic [LPI_W-1:0]  last_pair_index;
   dir_ram_req_type   dir_req;
   rng_ram_req_type   rng_req;
   logic [WORD_W-1:0] dir_rdata;
   logic [WORD_W-1:0] rng_rdata;

   rtcpm_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .last_pair_index (last_pair_index)
   );

   rtcpm_ram #(.DEPTH(DIRECT_SIZE), .WIDTH(WORD_W)) u_dir_ram (
      .clock (clock),
      .we    (dir_req.we),
      .waddr (dir_req.waddr),
      .wdata (dir_req.wdata),
      .re    (dir_req.re),
      .raddr (dir_req.raddr),
      .rdata (dir_rdata)
   );

   rtcpm_ram #(.DEPTH(RANGE_WORDS), .WIDTH(WORD_W)) u_rng_ram (
      .clock (clock),
      .we    (rng_req.we),
      .waddr (rng_req.waddr),
      .wdata (rng_req.wdata),
      .re    (rng_req.re),
      .raddr (rng_req.raddr),
      .rdata (rng_rdata)
   );

   rtcpm_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .last_pair_index (last_pair_index),
      .dir_req         (dir_req),
      .dir_rdata       (dir_rdata),
      .rng_req         (rng_req),
      .rng_rdata       (rng_rdata)
   );

endmodule

// ===== hw/rtl/rtcpm_ram.sv =====
`timescale 1ns / 1ps

module rtcpm_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/rtcpm_csr.sv =====
`timescale 1ns / 1ps

module rtcpm_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rtcpm_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   output logic [rtcpm_pkg::LPI_W-1:0]  last_pair_index
);
   import rtcpm_pkg::*;

   logic [LPI_W-1:0] lpi_ff;
   logic [LPI_W-1:0] lpi_in;
   logic             wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr == CSR_LAST_PAIR);

   always_comb begin
      lpi_in = lpi_ff;
      if (wr_hit) begin
         lpi_in = pwdata[LPI_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lpi_ff <= '0;
      end else begin
         lpi_ff <= lpi_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == CSR_LAST_PAIR) begin
         prdata = {{(32-LPI_W){1'b0}}, lpi_ff};
      end
   end

   assign last_pair_index = lpi_ff;

endmodule

// ===== hw/rtl/rtcpm_ctrl.sv =====
`timescale 1ns / 1ps

module rtcpm_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  rtcpm_pkg::req_type             req_data,
   output logic                           rsp_valid,
   output rtcpm_pkg::rsp_type             rsp_data,
   input  logic [rtcpm_pkg::LPI_W-1:0]    last_pair_index,
   output rtcpm_pkg::dir_ram_req_type     dir_req,
   input  logic [rtcpm_pkg::WORD_W-1:0]   dir_rdata,
   output rtcpm_pkg::rng_ram_req_type     rng_req,
   input  logic [rtcpm_pkg::WORD_W-1:0]   rng_rdata
);
   import rtcpm_pkg::*;

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] code_ff, code_in;
   logic [WORD_W-1:0] start_ff, start_in;
   logic [RNG_AW-1:0] lo_ff, lo_in;
   logic [RNG_AW-1:0] hi_ff, hi_in;
   logic [RNG_AW-1:0] mid_ff, mid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              query_oob;
   logic [RNG_AW-1:0] lo_n, hi_n;

   function automatic logic [RNG_AW-1:0] mid_of(input logic [RNG_AW-1:0] lo,
                                                input logic [RNG_AW-1:0] hi);
      logic [RNG_AW:0] sum;
      sum = {1'b0, lo} + {1'b0, hi} + {{RNG_AW{1'b0}}, 1'b1} + {{RNG_AW{1'b0}}, 1'b1};
      return {sum[RNG_AW:2], 1'b0};
   endfunction

   function automatic rsp_type decode(input logic [WORD_W-1:0] code,
                                      input logic [WORD_W-1:0] start_w,
                                      input logic [WORD_W-1:0] act);
      rsp_type r;
      r.mapped_code = '0;
      r.bad_action  = 1'b0;
      priority if (act[WORD_W-1]) begin
         r.mapped_code = code - start_w + ~act;
      end else if (act <= MAX_CODE) begin
         r.mapped_code = act;
      end else if (act == ACT_CLEAR) begin
         r.mapped_code = {code[WORD_W-1:1], 1'b0};
      end else if (act == ACT_SET) begin
         r.mapped_code = {code[WORD_W-1:1], 1'b1};
      end else if (act == ACT_DEC_SET) begin
         r.mapped_code = (code - 32'd1) | 32'd1;
      end else begin
         r.bad_action = 1'b1;
      end
      return r;
   endfunction

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign query_oob = accept && (req_data.mode == MODE_QUERY)
                      && ($unsigned(req_data.code) > MAX_CODE);

   // search step on the pair start read for mid_ff
   always_comb begin
      if ($signed(rng_rdata) <= $signed(code_ff)) begin
         lo_n = mid_ff;
         hi_n = hi_ff;
      end else begin
         lo_n = lo_ff;
         hi_n = mid_ff - {{(RNG_AW-2){1'b0}}, 2'd2};
      end
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      start_in     = start_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      dir_req.we    = accept && (req_data.mode == MODE_DIR_WR);
      dir_req.waddr = req_data.index[DIR_AW-1:0];
      dir_req.wdata = req_data.value;
      dir_req.re    = 1'b0;
      dir_req.raddr = req_data.code[DIR_AW-1:0];

      rng_req.we    = accept && (req_data.mode == MODE_RNG_WR);
      rng_req.waddr = req_data.index[RNG_AW-1:0];
      rng_req.wdata = req_data.value;
      rng_req.re    = 1'b0;
      rng_req.raddr = lo_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.mode == MODE_QUERY)) begin
               code_in = req_data.code;
               priority if (req_data.code[WORD_W-1:DIR_AW] == '0) begin
                  dir_req.re = 1'b1;
                  state_in   = ST_DIR;
               end else if (query_oob) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
               end else begin
                  lo_in    = '0;
                  hi_in    = {last_pair_index[LPI_W-1:1], 1'b0};
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_DIR: begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.mapped_code = dir_rdata;
            rsp_data_in.bad_action  = 1'b0;
            state_in                = ST_IDLE;
         end
         ST_SEARCH: begin
            rng_req.re = 1'b1;
            if (lo_ff < hi_ff) begin
               mid_in        = mid_of(lo_ff, hi_ff);
               rng_req.raddr = mid_in;
               state_in      = ST_CMP;
            end else begin
               rng_req.raddr = lo_ff;
               state_in      = ST_START;
            end
         end
         ST_CMP: begin
            lo_in      = lo_n;
            hi_in      = hi_n;
            rng_req.re = 1'b1;
            if (lo_n < hi_n) begin
               mid_in        = mid_of(lo_n, hi_n);
               rng_req.raddr = mid_in;
            end else begin
               rng_req.raddr = lo_n;
               state_in      = ST_START;
            end
         end
         ST_START: begin
            start_in      = rng_rdata;
            rng_req.re    = 1'b1;
            rng_req.raddr = {lo_ff[RNG_AW-1:1], 1'b1};
            state_in      = ST_ACT;
         end
         ST_ACT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = decode(code_ff, start_ff, rng_rdata);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      start_ff    <= start_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_cmp_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (lo_ff < hi_ff) && (mid_ff > lo_ff) && (mid_ff <= hi_ff))
      else $error("search window empty in compare");

   a_pair_even: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP || state_ff == ST_START) |-> !lo_ff[0] && !hi_ff[0])
      else $error("search bound not on a pair");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DIR || state_ff == ST_ACT || query_oob))
      else $error("result without a finished query");

   a_dir_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && state_in == ST_DIR) |=> (state_ff == ST_DIR) && !rsp_valid_ff)
      else $error("direct read sequencing");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !dir_req.we && !rng_req.we)
      else $error("table write while busy");

endmodule

// ===== dv/range_table_code_point_mapper_top_tb.sv =====
`timescale 1ns / 1ps

module range_table_code_point_mapper_top_tb;
   import rtcpm_pkg::*;

   localparam logic [1:0] MODE_NONE     = 2'd3;
   localparam int         CYCLE_LIMIT   = 500_000;
   localparam int         PHASE_ITEMS   = 64;
   localparam int         DRAIN_WAIT    = 16;
   localparam int         DIRECT_LOADED = 32;

   class code_map_scoreboard;
      logic [WORD_W-1:0] direct_tbl [DIRECT_SIZE];
      logic [WORD_W-1:0] range_tbl [RANGE_WORDS];
      logic [LPI_W-1:0]  last_pair;
      rsp_type           expected_maps[$];
      int                errors;

      function new();
         last_pair = '0;
         errors = 0;
      endfunction

      function logic [WORD_W-1:0] range_word(int unsigned i);
         return (i < RANGE_WORDS) ? range_tbl[i] : '0;
      endfunction

      function rsp_type map_code(logic [WORD_W-1:0] code);
         rsp_type           r;
         int unsigned       lo;
         int unsigned       hi;
         int unsigned       mid;
         logic [WORD_W-1:0] base;
         logic [WORD_W-1:0] act;
         r = '0;
         if (code < DIRECT_SIZE) begin
            r.mapped_code = direct_tbl[code[DIR_AW-1:0]];
            return r;
         end
         if (code > MAX_CODE) return r;
         lo = 0;
         hi = last_pair & 10'h3FE;
         while (lo < hi) begin
            mid = ((lo + hi + 2) >> 2) << 1;
            if ($signed(range_word(mid)) <= $signed(code)) lo = mid;
            else hi = mid - 2;
         end
         base = range_word(lo);
         act  = range_word(lo + 1);
         if (act[WORD_W-1]) r.mapped_code = code - base + ~act;
         else if (act <= MAX_CODE) r.mapped_code = act;
         else begin
            case (act)
               ACT_CLEAR:   r.mapped_code = code & ~32'd1;
               ACT_SET:     r.mapped_code = code | 32'd1;
               ACT_DEC_SET: r.mapped_code = (code - 32'd1) | 32'd1;
               default:     r.bad_action = 1'b1;
            endcase
         end
         return r;
      endfunction

      task report(string msg);
         if (errors < 100) $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function void note_item(req_type it);
         case (it.mode)
            MODE_DIR_WR: direct_tbl[it.index] = it.value;
            MODE_RNG_WR: range_tbl[it.index] = it.value;
            MODE_QUERY:  expected_maps.push_back(map_code(it.code));
            default: ;
         endcase
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_maps.size() == 0) begin
            report($sformatf("result %h with no query pending", got));
            return;
         end
         want = expected_maps.pop_front();
         if (got.mapped_code !== want.mapped_code)
            report($sformatf("mapped_code %h, expected %h", got.mapped_code, want.mapped_code));
         if (got.bad_action !== want.bad_action)
            report($sformatf("bad_action %b, expected %b", got.bad_action, want.bad_action));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [CSR_AW-1:0]  paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   code_map_scoreboard sb;
   logic [WORD_W-1:0]  range_img [RANGE_WORDS];
   logic [LPI_W-1:0]   cur_lpi;
   int                 idle_pct;
   int                 cycles = 0;

   range_table_code_point_mapper_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_data);
         if (start && !busy) sb.note_item(req_data);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("range_table_code_point_mapper_top_tb: done, errors");
         $finish;
      end
   end

   function req_type make_req(logic [1:0] m, logic [9:0] idx, logic [31:0] val,
                              logic [31:0] code);
      req_type r;
      r.mode  = m;
      r.index = idx;
      r.value = val;
      r.code  = code;
      return r;
   endfunction

   // start stays high from one item to the next unless the sender idles
   task automatic drive_item(req_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic query(logic [31:0] code);
      drive_item(make_req(MODE_QUERY, 10'($urandom_range(0, 1023)), $urandom(), code));
   endtask

   task automatic write_range(logic [9:0] idx, logic [31:0] val);
      range_img[idx] = val;
      drive_item(make_req(MODE_RNG_WR, idx, val, $urandom()));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_maps.size() != 0) @(negedge clock);
   endtask

   task automatic settle();
      wait_drained();
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic set_last_pair(logic [LPI_W-1:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_LAST_PAIR;
      pwdata  <= 32'(val);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.last_pair = val;
      cur_lpi = val;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== 32'(val))
         sb.report($sformatf("last_pair_index read %h, expected %h", prdata, val));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function logic [31:0] random_action();
      case ($urandom_range(0, 7))
         0, 1:    return ~32'($urandom_range(0, MAX_CODE));
         2:       return $urandom_range(0, MAX_CODE);
         3:       return ACT_CLEAR;
         4:       return ACT_SET;
         5:       return ACT_DEC_SET;
         6:       return $urandom_range(MAX_CODE + 1, ACTION_BASE - 1);
         default: return $urandom_range(ACT_DEC_SET + 1, 32'h7FFF_FFFF);
      endcase
   endfunction

   // direct codes stay within the loaded direct entries
   function logic [31:0] random_code();
      int unsigned p;
      p = $urandom_range(0, cur_lpi >> 1);
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, DIRECT_LOADED - 1);
         1, 2:    return $urandom_range(DIRECT_SIZE, MAX_CODE);
         3:       return $urandom() | 32'(DIRECT_SIZE);
         4:       return $urandom_range(MAX_CODE + 1, 32'hFFFF_FFFF);
         default: return range_img[2 * p] + $urandom_range(0, 2) - 1;
      endcase
   endfunction

   // sorted starts above the direct table, one action per pair;
   // only the words the search can reach are written
   task automatic load_ranges();
      int unsigned base;
      int          n_words;
      base = $urandom_range(DIRECT_SIZE + 1, 3000);
      n_words = 2 * int'(cur_lpi >> 1) + 2;
      for (int p = 0; p < RANGE_WORDS / 2; p++) begin
         range_img[2 * p]     = base;
         range_img[2 * p + 1] = random_action();
         base += $urandom_range(1, 2100);
      end
      for (int i = 0; i < n_words; i++)
         drive_item(make_req(MODE_RNG_WR, 10'(i), range_img[i], $urandom()));
   endtask

   task automatic directed_items();
      logic [31:0] acts [8];
      acts = '{~32'd5, 32'd0, MAX_CODE, ACT_CLEAR, ACT_SET, ACT_DEC_SET,
               ACT_DEC_SET + 32'd1, MAX_CODE + 32'd1};
      write_range(10'd0, 32'h0000_1000);
      foreach (acts[i]) begin
         write_range(10'd1, acts[i]);
         query(32'h0000_1235);
      end
      query(32'd0);
      query(32'h0000_0FFF);
      drive_item(make_req(MODE_DIR_WR, 10'd1023, 32'h8000_0000, $urandom()));
      query(DIRECT_SIZE - 1);
      query(DIRECT_SIZE);
      query(MAX_CODE);
      query(MAX_CODE + 32'd1);
      query(32'hFFFF_FFFF);
      query(32'h8000_0000);
      query(32'h7FFF_FFFF);
      drive_item(make_req(MODE_NONE, 10'd5, $urandom(), 32'd7));
   endtask

   task automatic random_items(int n);
      int count;
      int k;
      count = 0;
      while (count < n) begin
         k = $urandom_range(0, 99);
         if (k < 72) begin
            query(random_code());
            count++;
         end else if (k < 81) begin
            drive_item(make_req(MODE_DIR_WR, 10'($urandom_range(0, 1023)), $urandom(),
                                $urandom()));
            count++;
         end else if (k < 88) begin
            write_range(10'(2 * $urandom_range(0, cur_lpi >> 1) + 1), random_action());
            count++;
         end else if (k < 92) begin
            write_range(10'($urandom_range(0, 1023)), $urandom());
            count++;
         end else if (k < 97) begin
            drive_item(make_req(MODE_NONE, 10'($urandom_range(0, 1023)), $urandom(),
                                $urandom()));
         end else begin
            wait_drained();
         end
      end
   endtask

   initial begin
      logic [LPI_W-1:0] phase_lpi [6];
      sb       = new();
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      cur_lpi  = '0;
      idle_pct = 36;
      phase_lpi = '{10'd62, 10'd63, 10'd1, 10'd2,
                    10'(2 * $urandom_range(0, 31)), 10'($urandom_range(0, 63))};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_last_pair(10'd0);
      for (int i = 0; i < DIRECT_LOADED; i++)
         drive_item(make_req(MODE_DIR_WR, 10'(i), $urandom(), $urandom()));
      load_ranges();
      directed_items();

      foreach (phase_lpi[ph]) begin
         settle();
         set_last_pair(phase_lpi[ph]);
         idle_pct = (ph == 2) ? 0 : 36;
         load_ranges();
         random_items(PHASE_ITEMS);
      end

      settle();
      if (sb.errors == 0) begin
         $display("range_table_code_point_mapper_top_tb: done, clean");
      end else begin
         $display("range_table_code_point_mapper_top_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== range_table_code_point_mapper_top.f =====
hw/rtl/rtcpm_pkg.sv
hw/rtl/rtcpm_ram.sv
hw/rtl/rtcpm_csr.sv
hw/rtl/rtcpm_ctrl.sv
hw/rtl/range_table_code_point_mapper_top.sv
dv/range_table_code_point_mapper_top_tb.sv
